// File: sv/mfe_pkg.sv
// Package for the MAVLink v2 yaw-rate frame encoder.
// Holds the queue entry type, status codes, frame constants and the CRC step.
// No dependencies.
`timescale 1ns / 1ps

package mfe_pkg;

  // Result status codes
  localparam logic [2:0] STATUS_SENT     = 3'd0;
  localparam logic [2:0] STATUS_INVALID  = 3'd1;
  localparam logic [2:0] STATUS_NONFIN   = 3'd2;
  localparam logic [2:0] STATUS_VEL      = 3'd3;
  localparam logic [2:0] STATUS_YAW_OVER = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_SRC_SYS  = 3'd0;
  localparam logic [2:0] REG_SRC_COMP = 3'd1;
  localparam logic [2:0] REG_TGT_SYS  = 3'd2;
  localparam logic [2:0] REG_TGT_COMP = 3'd3;
  localparam logic [2:0] REG_YAW_LIM  = 3'd4;

  // Frame constants
  localparam logic [7:0]  STX_BYTE      = 8'hFD;
  localparam logic [7:0]  PAYLOAD_LEN   = 8'd53;
  localparam logic [7:0]  MSG_ID        = 8'd84;
  localparam logic [7:0]  MSG_SEED_BYTE = 8'd143;
  localparam logic [7:0]  COORD_FRAME   = 8'd8;
  localparam logic [15:0] TYPE_MASK     = 16'h0007 | 16'h0038 | 16'h01C0 | 16'h0400;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;

  // Word positions within the 17-word frame
  localparam int          FRAME_WORDS = 17;
  localparam logic [4:0]  WORD_HDR0   = 5'd0;
  localparam logic [4:0]  WORD_HDR1   = 5'd1;
  localparam logic [4:0]  WORD_YAW_LO = 5'd13;
  localparam logic [4:0]  WORD_YAW_HI = 5'd14;
  localparam logic [4:0]  WORD_TAIL   = 5'd15;
  localparam logic [4:0]  WORD_LAST   = 5'(FRAME_WORDS - 1);

  // Classified command held between front and back
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] yaw;
  } cmd_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // CRC-16/MCRF4XX over one byte
  function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// File: sv/mavlink2_yaw_rate_frame_encoder_unit.sv
// Path: an accepted input beat is written into the command queue, and the first
// result beat of its command is then held in the back-end output register.
// Throughput: a passing command yields 17 frame words, one frame word per cycle
// from the back-end word sequencer while the output is not stalled; a rejected
// one yields a single status beat. The front keeps accepting while the command
// queue has room. Reset: synchronous; clears queue, output valid and sequence
// byte, and loads ids to 1 and the yaw limit to 1.0.
`timescale 1ns / 1ps

module mavlink2_yaw_rate_frame_encoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  // Command stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // vel_x_bits, vel_y_bits, yaw_bits, confidence_bits
  input  logic [0:0]   s_tuser,  // cmd_valid
  // Frame stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,  // frame_word, byte_count, zero pad
  output logic         m_tlast,  // last_word
  output logic [2:0]   m_tuser,  // status
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import mfe_pkg::*;

  logic [7:0]  source_system_id;
  logic [7:0]  source_component_id;
  logic [7:0]  target_system_id;
  logic [7:0]  target_component_id;
  logic [30:0] yaw_limit_bits;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  cmd_t        front_cmd;
  cmd_t        q_head;
  q_stat_t     q_stat;
  logic        q_push;
  logic        q_pop;
  logic [31:0] frame_word;
  logic [2:0]  byte_count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_system_id    <= 8'd1;
      source_component_id <= 8'd1;
      target_system_id    <= 8'd1;
      target_component_id <= 8'd1;
      yaw_limit_bits      <= 31'h3F80_0000;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SRC_SYS:  source_system_id    <= pwdata[7:0];
        REG_SRC_COMP: source_component_id <= pwdata[7:0];
        REG_TGT_SYS:  target_system_id    <= pwdata[7:0];
        REG_TGT_COMP: target_component_id <= pwdata[7:0];
        REG_YAW_LIM:  yaw_limit_bits      <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_SRC_SYS:  prdata = {24'h0, source_system_id};
      REG_SRC_COMP: prdata = {24'h0, source_component_id};
      REG_TGT_SYS:  prdata = {24'h0, target_system_id};
      REG_TGT_COMP: prdata = {24'h0, target_component_id};
      REG_YAW_LIM:  prdata = {1'b0, yaw_limit_bits};
      default:      prdata = 32'h0;
    endcase
  end

  // Accept a beat whenever the queue has room
  assign s_tready = !q_stat.full;
  assign q_push   = s_tvalid && s_tready;

  mfe_front u_front (
    .cmd_valid       (s_tuser[0]),
    .vel_x_bits      (s_tdata[31:0]),
    .vel_y_bits      (s_tdata[63:32]),
    .yaw_bits        (s_tdata[95:64]),
    .confidence_bits (s_tdata[127:96]),
    .yaw_limit_bits  (yaw_limit_bits),
    .cmd             (front_cmd)
  );

  mfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  mfe_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (!q_stat.empty),
    .head                (q_head),
    .pop                 (q_pop),
    .source_system_id    (source_system_id),
    .source_component_id (source_component_id),
    .target_system_id    (target_system_id),
    .target_component_id (target_component_id),
    .out_valid           (m_tvalid),
    .out_ready           (m_tready),
    .frame_word          (frame_word),
    .byte_count          (byte_count),
    .last_word           (m_tlast),
    .status              (m_tuser)
  );

  assign m_tdata = {5'b00000, byte_count, frame_word};

  // A beat carries no bytes exactly when it reports a rejection
  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((byte_count == 3'd0) == (m_tuser != STATUS_SENT)))
    else $error("byte count disagrees with status");

  // The closing frame word holds one byte with zero upper bits
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && m_tuser == STATUS_SENT) |->
      (byte_count == 3'd1 && frame_word[31:8] == 24'h0))
    else $error("malformed final frame word");

  // The back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty command queue");

endmodule

// File: sv/mfe_front.sv
// Front end: accepts command beats and classifies them into a status.
// Depends on mfe_pkg.
`timescale 1ns / 1ps

module mfe_front (
  input  logic             cmd_valid,
  input  logic [31:0]      vel_x_bits,
  input  logic [31:0]      vel_y_bits,
  input  logic [31:0]      yaw_bits,
  input  logic [31:0]      confidence_bits,
  input  logic [30:0]      yaw_limit_bits,
  output mfe_pkg::cmd_t    cmd
);
  import mfe_pkg::*;

  logic nonfin;
  logic vel_nz;
  logic yaw_over;

  // Exponent all ones marks infinity or NaN
  assign nonfin = (&vel_x_bits[30:23]) | (&vel_y_bits[30:23]) |
                  (&yaw_bits[30:23]) | (&confidence_bits[30:23]);
  // Minus zero counts as zero: ignore the sign bit
  assign vel_nz   = (|vel_x_bits[30:0]) | (|vel_y_bits[30:0]);
  assign yaw_over = yaw_bits[30:0] > yaw_limit_bits;

  // First failing check sets status
  always_comb begin
    cmd.yaw = yaw_bits;
    if (!cmd_valid) begin
      cmd.status = STATUS_INVALID;
    end else if (nonfin) begin
      cmd.status = STATUS_NONFIN;
    end else if (vel_nz) begin
      cmd.status = STATUS_VEL;
    end else if (yaw_over) begin
      cmd.status = STATUS_YAW_OVER;
    end else begin
      cmd.status = STATUS_SENT;
    end
  end

endmodule

// File: sv/mfe_queue.sv
// Short FIFO of classified commands between front and back.
// Depends on mfe_pkg.
`timescale 1ns / 1ps

module mfe_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mfe_pkg::cmd_t     push_data,
  input  logic              pop,
  output mfe_pkg::cmd_t     head,
  output mfe_pkg::q_stat_t  stat
);
  import mfe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  // Store pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/mfe_back.sv
// Back end: turns queued commands into status beats or 17-word frames,
// running the CRC four bytes per word. Depends on mfe_pkg.
`timescale 1ns / 1ps

module mfe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mfe_pkg::cmd_t   head,
  output logic            pop,
  input  logic [7:0]      source_system_id,
  input  logic [7:0]      source_component_id,
  input  logic [7:0]      target_system_id,
  input  logic [7:0]      target_component_id,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     frame_word,
  output logic [2:0]      byte_count,
  output logic            last_word,
  output logic [2:0]      status
);
  import mfe_pkg::*;

  logic [4:0]  idx;
  logic [7:0]  seq_count;
  logic [15:0] crc;
  logic        advance;
  logic        is_frame;
  logic [31:0] word_pre;
  logic [15:0] crc_a;
  logic [15:0] crc_b;
  logic [15:0] crc_c;
  logic [15:0] crc_next;
  logic [31:0] word_out;

  assign advance  = q_valid && (!out_valid || out_ready);
  assign is_frame = (head.status == STATUS_SENT);
  assign pop      = advance && (!is_frame || idx == WORD_LAST);

  // Bytes of the current word; the tail word carries the message seed byte in
  // its top lane until the CRC low byte replaces it
  always_comb begin
    case (idx)
      WORD_HDR0:   word_pre = {8'h00, 8'h00, PAYLOAD_LEN, STX_BYTE};
      WORD_HDR1:   word_pre = {MSG_ID, source_component_id, source_system_id, seq_count};
      WORD_YAW_LO: word_pre = {head.yaw[15:0], 16'h0000};
      WORD_YAW_HI: word_pre = {TYPE_MASK[15:8], TYPE_MASK[7:0], head.yaw[31:16]};
      WORD_TAIL:   word_pre = {MSG_SEED_BYTE, COORD_FRAME, target_component_id,
                               target_system_id};
      WORD_LAST:   word_pre = {24'h000000, crc[15:8]};
      default:     word_pre = 32'h0000_0000;
    endcase
  end

  // Run the CRC over the word's bytes; skip the start byte on the first word
  always_comb begin
    crc_a    = (idx == WORD_HDR0) ? CRC_INIT : crc_step(word_pre[7:0], crc);
    crc_b    = crc_step(word_pre[15:8], crc_a);
    crc_c    = crc_step(word_pre[23:16], crc_b);
    crc_next = crc_step(word_pre[31:24], crc_c);
    word_out = (idx == WORD_TAIL) ? {crc_next[7:0], word_pre[23:0]} : word_pre;
  end

  // Hold output beat, step word index and sequence byte
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      seq_count <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (is_frame) begin
          if (idx == WORD_LAST) begin
            idx       <= '0;
            seq_count <= seq_count + 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      if (is_frame) begin
        crc        <= crc_next;
        frame_word <= word_out;
        byte_count <= (idx == WORD_LAST) ? 3'd1 : 3'd4;
        last_word  <= (idx == WORD_LAST);
        status     <= STATUS_SENT;
      end else begin
        frame_word <= 32'h0000_0000;
        byte_count <= 3'd0;
        last_word  <= 1'b1;
        status     <= head.status;
      end
    end
  end

endmodule
